### sv/pir_sensor_supervisor_assert.svh
// assertion helpers used by the supervisor core
`ifndef PIR_SENSOR_SUPERVISOR_ASSERT_SVH
`define PIR_SENSOR_SUPERVISOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pss_pkg.sv
package pss_pkg;

  localparam int unsigned TimeBits = 32;

  localparam int unsigned IgnoreSpanInt = 75000 / 15;
  localparam int unsigned CheckSpanInt  = 5000;

  typedef logic [TimeBits-1:0] time_t;

  localparam time_t IgnoreSpan = time_t'(IgnoreSpanInt);
  localparam time_t CheckSpan  = time_t'(CheckSpanInt);

  localparam logic [23:0] ProbeAllOnes = 24'hffffff;
  localparam logic [5:0]  DelayRun     = 6'd50;
  localparam logic [5:0]  DelayInit    = 6'd10;

  // configuration register indexes
  localparam logic [0:0] RegSensitivity = 1'd0;
  localparam logic [0:0] RegBlankPeriod = 1'd1;

  localparam logic [1:0]  SensReset  = 2'd2;
  localparam logic [31:0] BlankReset = 32'd1000;

  typedef enum logic [1:0] {
    ModeError  = 2'd0,
    ModeInit   = 2'd1,
    ModeIgnore = 2'd2,
    ModeCheck  = 2'd3
  } mode_e;

  typedef struct packed {
    time_t       now;
    logic        motion_level;
    logic [23:0] probe_readout;
  } in_word_t;

  typedef struct packed {
    logic        motion_event;
    logic        error_event;
    logic        clear_event;
    logic        send_probe;
    logic        send_config;
    logic [24:0] config_word;
    logic [5:0]  next_delay;
    logic        motion_valid;
    mode_e       mode_now;
  } res_t;

  // sensitivity level to detection threshold
  function automatic logic [7:0] thresh_of(input logic [1:0] level);
    logic [7:0] t;
    case (level)
      2'd0:    t = 8'd150;
      2'd1:    t = 8'd70;
      2'd2:    t = 8'd20;
      default: t = 8'd9;
    endcase
    return t;
  endfunction

  // event unit word: threshold at bit 17, blind time code 2 at bit 7, fixed 0x10
  function automatic logic [24:0] make_word(input logic [1:0] level);
    return {thresh_of(level), 17'd0} | 25'(2 << 7) | 25'h10;
  endfunction

  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TimeBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeBits] ? '1 : s[TimeBits-1:0];
  endfunction

endpackage

### sv/pss_in_stage.sv
module pss_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pss_pkg::in_word_t word_i,
  input  logic              advance_i,
  output logic              valid_o,
  output pss_pkg::in_word_t word_o
);
  import pss_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     load;

  // hold while a word sits here and the core cannot take it
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### sv/pss_core.sv
module pss_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              step_i,
  input  pss_pkg::in_word_t word_i,
  output pss_pkg::res_t     res_o
);
  import pss_pkg::*;

  `include "pir_sensor_supervisor_assert.svh"

  logic [1:0]  sens_q;
  logic [31:0] blank_period_q;

  mode_e mode_q, mode_d;
  time_t ignore_dl_q, ignore_dl_d;
  time_t blank_dl_q, blank_dl_d;
  time_t check_dl_q, check_dl_d;
  logic  valid_flag_q, valid_flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q         <= SensReset;
      blank_period_q <= BlankReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegSensitivity: sens_q         <= cfg_wdata_i[1:0];
        RegBlankPeriod: blank_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d       = mode_q;
    ignore_dl_d  = ignore_dl_q;
    blank_dl_d   = blank_dl_q;
    check_dl_d   = check_dl_q;
    valid_flag_d = valid_flag_q;
    res_o        = '0;
    res_o.next_delay = DelayRun;

    unique case (mode_q)
      ModeInit: begin
        res_o.send_config = 1'b1;
        res_o.config_word = make_word(sens_q);
        res_o.clear_event = 1'b1;
        res_o.next_delay  = DelayInit;
        mode_d            = ModeIgnore;
      end
      ModeIgnore: begin
        // zero deadline means not armed yet
        if (ignore_dl_q == '0) begin
          ignore_dl_d = sat_add(word_i.now, IgnoreSpan);
        end
        res_o.clear_event = word_i.motion_level;
        mode_d = (word_i.now >= ignore_dl_d) ? ModeCheck : ModeIgnore;
      end
      ModeCheck: begin
        if (word_i.motion_level) begin
          res_o.clear_event = 1'b1;
          if (word_i.now >= blank_dl_q) begin
            res_o.motion_event = 1'b1;
            blank_dl_d   = sat_add(word_i.now, time_t'(blank_period_q));
            valid_flag_d = 1'b1;
          end
        end
        if (word_i.now >= check_dl_q) begin
          check_dl_d        = sat_add(word_i.now, CheckSpan);
          res_o.send_probe  = 1'b1;
          res_o.clear_event = 1'b1;
          if (word_i.probe_readout == ProbeAllOnes || word_i.probe_readout == '0) begin
            valid_flag_d      = 1'b0;
            res_o.error_event = 1'b1;
            mode_d            = ModeInit;
          end else begin
            res_o.send_config = 1'b1;
            res_o.config_word = make_word(sens_q);
          end
        end
      end
      default: begin
        valid_flag_d      = 1'b0;
        res_o.error_event = 1'b1;
        mode_d            = ModeInit;
      end
    endcase

    res_o.motion_valid = valid_flag_d;
    res_o.mode_now     = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeInit;
      ignore_dl_q  <= '0;
      blank_dl_q   <= '0;
      check_dl_q   <= '0;
      valid_flag_q <= 1'b0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      ignore_dl_q  <= ignore_dl_d;
      blank_dl_q   <= blank_dl_d;
      check_dl_q   <= check_dl_d;
      valid_flag_q <= valid_flag_d;
    end
  end

  `PSS_ASSERT_SAME(a_err_reinit, step_i && res_o.error_event,
                   res_o.mode_now == ModeInit && !res_o.motion_valid,
                   "error word without re-initialize")
  `PSS_ASSERT_NEXT(a_init_to_ignore, step_i && mode_q == ModeInit,
                   mode_q == ModeIgnore, "initialize did not move to ignore")
  `PSS_ASSERT_SAME(a_word_gated, !res_o.send_config, res_o.config_word == '0,
                   "config word present without send")

endmodule

### sv/pir_sensor_supervisor.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+--------------------------------------
// input    | in        | in_valid_i / in_stall_o | now_i, motion_level_i, probe_readout_i
// result   | out       | out_valid_o/out_stall_i | motion_event_o .. mode_now_o
// config   | in        | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// one word per cycle sustained while the result side does not stall; an accepted input
// word is held in the input register, then its mode step goes into the result register
// mode and deadlines update when a word leaves the input register, so the
// next word in line always sees the state left by the previous one
// reset puts mode at initialize, clears deadlines and the latched motion flag
// a stalled result holds the result register and, once it is full, the input side
module pir_sensor_supervisor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // tick words in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_i,
  input  logic        motion_level_i,
  input  logic [23:0] probe_readout_i,
  // result words out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        motion_event_o,
  output logic        error_event_o,
  output logic        clear_event_o,
  output logic        send_probe_o,
  output logic        send_config_o,
  output logic [24:0] config_word_o,
  output logic [5:0]  next_delay_o,
  output logic        motion_valid_o,
  output logic [1:0]  mode_now_o
);
  import pss_pkg::*;

  in_word_t in_word, stage_word;
  logic     stage_valid;
  logic     out_ready, advance;
  res_t     step_res, res_q;
  logic     out_valid_q, out_valid_d;

  assign in_word.now           = time_t'(now_i);
  assign in_word.motion_level  = motion_level_i;
  assign in_word.probe_readout = probe_readout_i;

  // result register frees up when empty or being taken this cycle
  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = stage_valid && out_ready;

  pss_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .word_i     (in_word),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .word_o     (stage_word)
  );

  pss_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .word_i      (stage_word),
    .res_o       (step_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motion_event_o = res_q.motion_event;
  assign error_event_o  = res_q.error_event;
  assign clear_event_o  = res_q.clear_event;
  assign send_probe_o   = res_q.send_probe;
  assign send_config_o  = res_q.send_config;
  assign config_word_o  = res_q.config_word;
  assign next_delay_o   = res_q.next_delay;
  assign motion_valid_o = res_q.motion_valid;
  assign mode_now_o     = res_q.mode_now;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pss_pkg::*;

  // run shape
  localparam int unsigned RandomTicks = 1925;
  localparam int unsigned PhaseTicks  = 150;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned DrainCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] now_i;
  logic        motion_level_i;
  logic [23:0] probe_readout_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        motion_event_o;
  logic        error_event_o;
  logic        clear_event_o;
  logic        send_probe_o;
  logic        send_config_o;
  logic [24:0] config_word_o;
  logic [5:0]  next_delay_o;
  logic        motion_valid_o;
  logic [1:0]  mode_now_o;

  pir_sensor_supervisor DUT (.*);

  // predicted supervisor state, mirrors the block after every accepted tick
  mode_e       sup_mode;
  time_t       sup_ignore_at;   // zero means the ignore deadline was never set
  time_t       sup_blank_at;
  time_t       sup_probe_at;
  logic        sup_latched;
  logic [1:0]  sup_sens;
  logic [31:0] sup_blank_len;

  // result words still owed by the block, oldest first
  res_t        due_reports[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  // time of the last tick sent, random traffic carries on from here
  time_t       tick_time;

  // stretches of back-to-back traffic on either side
  bit          in_calm;
  bit          out_calm;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // deadline sums stick at the top of the time range instead of wrapping
  function automatic time_t clamp_sum(input time_t base, input time_t span);
    logic [TimeBits:0] s;
    s = {1'b0, base} + {1'b0, span};
    return s[TimeBits] ? '1 : s[TimeBits-1:0];
  endfunction

  // event unit word: threshold from the sensitivity choice, blind time code 2, fixed low bits
  function automatic logic [24:0] event_unit_word(input logic [1:0] lvl);
    logic [7:0] thr;
    case (lvl)
      2'd0:    thr = 8'd150;
      2'd1:    thr = 8'd70;
      2'd2:    thr = 8'd20;
      default: thr = 8'd9;
    endcase
    return (25'(thr) << 17) | (25'd2 << 7) | 25'h10;
  endfunction

  // one scheduler tick through the mode machine, returns the word the block must report
  function automatic res_t supervise_tick(input in_word_t w);
    res_t r;
    r            = '0;
    r.next_delay = DelayRun;
    case (sup_mode)
      ModeInit: begin
        r.send_config = 1'b1;
        r.config_word = event_unit_word(sup_sens);
        r.clear_event = 1'b1;
        r.next_delay  = DelayInit;
        sup_mode      = ModeIgnore;
      end
      ModeIgnore: begin
        // deadline is armed once and kept, so a later re-init may skip the wait
        if (sup_ignore_at == '0) sup_ignore_at = clamp_sum(w.now, IgnoreSpan);
        if (w.motion_level) r.clear_event = 1'b1;
        sup_mode = (w.now >= sup_ignore_at) ? ModeCheck : ModeIgnore;
      end
      ModeCheck: begin
        if (w.motion_level) begin
          // report only outside the blanking window, each report reopens it
          if (w.now >= sup_blank_at) begin
            r.motion_event = 1'b1;
            sup_blank_at   = clamp_sum(w.now, sup_blank_len);
            sup_latched    = 1'b1;
          end
          r.clear_event = 1'b1;
        end
        if (w.now >= sup_probe_at) begin
          sup_probe_at  = clamp_sum(w.now, CheckSpan);
          r.send_probe  = 1'b1;
          r.clear_event = 1'b1;
          // stuck line reads all ones or all zeros: error and back to init
          if (w.probe_readout == ProbeAllOnes || w.probe_readout == '0) begin
            sup_latched   = 1'b0;
            r.error_event = 1'b1;
            sup_mode      = ModeInit;
          end else begin
            r.send_config = 1'b1;
            r.config_word = event_unit_word(sup_sens);
          end
        end
      end
      default: begin
        sup_latched   = 1'b0;
        r.error_event = 1'b1;
        sup_mode      = ModeInit;
      end
    endcase
    r.motion_valid = sup_latched;
    r.mode_now     = sup_mode;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // drive one tick word, wait for it to be taken, then queue its expected result
  task automatic send_tick(input time_t at, input logic level, input logic [23:0] readout);
    int unsigned gap;
    in_word_t    w;
    w.now           = at;
    w.motion_level  = level;
    w.probe_readout = readout;
    if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    now_i           <= at;
    motion_level_i  <= level;
    probe_readout_i <= readout;
    do @(posedge clk_i); while (in_stall_o);
    due_reports.push_back(supervise_tick(w));
    tick_time = at;
  endtask

  // stop sending and let every owed result come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_reports.size() != 0);
  endtask

  // write both registers back to back, block must be idle
  task automatic reconfigure(input logic [31:0] sens_data, input logic [31:0] blank_data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegSensitivity;
    cfg_wdata_i <= sens_data;
    @(posedge clk_i);
    sup_sens    = sens_data[1:0];
    cfg_index_i <= RegBlankPeriod;
    cfg_wdata_i <= blank_data;
    @(posedge clk_i);
    sup_blank_len = blank_data;
    cfg_we_i <= 1'b0;
  endtask

  // reset defaults: init word, then motion ignored until the deadline, boundary hit exactly
  task automatic test_ignore_window();
    send_tick(32'd100, 1'b0, 24'h000000);
    send_tick(32'd110, 1'b1, 24'hffffff);
    send_tick(32'd5109, 1'b0, 24'h123456);
    send_tick(32'd5110, 1'b1, 24'h000000);
  endtask

  // reports, blanking window edges and a good probe
  task automatic test_motion_blanking();
    send_tick(32'd5200, 1'b1, 24'h123456);
    send_tick(32'd6199, 1'b1, 24'h654321);
    send_tick(32'd6200, 1'b1, 24'h000000);
    send_tick(32'd7000, 1'b0, 24'h000000);
    send_tick(32'd10200, 1'b0, 24'h000001);
    send_tick(32'd10300, 1'b1, 24'hfffffe);
  endtask

  // stuck-high probe together with a report in the same tick, then a stuck-low probe
  task automatic test_probe_failure();
    send_tick(32'd15200, 1'b1, 24'hffffff);
    send_tick(32'd15210, 1'b1, 24'h000000);
    send_tick(32'd15220, 1'b1, 24'h000000);
    send_tick(32'd20200, 1'b0, 24'h000000);
  endtask

  // every sensitivity choice through the init word or a good probe, junk in the upper bits
  task automatic test_sensitivity();
    wait_drained();
    reconfigure({30'($urandom()), 2'd0}, sup_blank_len);
    send_tick(tick_time + 32'd10, 1'b0, 24'h000000);
    send_tick(tick_time + 32'd10, 1'b0, 24'h000000);
    wait_drained();
    reconfigure({30'($urandom()), 2'd1}, sup_blank_len);
    send_tick(sup_probe_at, 1'b0, 24'h800000);
    wait_drained();
    reconfigure({30'($urandom()), 2'd2}, sup_blank_len);
    send_tick(sup_probe_at, 1'b1, 24'h7fffff);
    wait_drained();
    reconfigure({30'($urandom()), 2'd3}, sup_blank_len);
    send_tick(sup_probe_at, 1'b0, 24'h0f0f0f);
  endtask

  // mostly forward-running time with random motion and probe data
  task automatic test_random_ticks();
    int unsigned roll;
    time_t       step;
    logic [23:0] readout;
    for (int unsigned k = 0; k < RandomTicks; k++) begin
      // new register setting every phase, first phase with no blanking at all
      if (k % PhaseTicks == 0) begin
        wait_drained();
        if (k == 0 || $urandom_range(0, 3) == 0) reconfigure($urandom(), 32'd0);
        else reconfigure($urandom(), 32'($urandom_range(1, 12000)));
      end
      roll = $urandom_range(0, 99);
      if (roll < 3 && tick_time < 32'he000_0000) begin
        // long leap so the upper time bits move too
        step      = $urandom_range(0, 32'h0800_0000);
        tick_time = tick_time + step;
      end else if (roll < 8 && tick_time > 32'd3000) begin
        // time running backward, deadlines look far away
        step      = $urandom_range(0, 3000);
        tick_time = tick_time - step;
      end else if (roll < 20) begin
        step      = $urandom_range(3000, 6000);
        tick_time = tick_time + step;
      end else begin
        step      = $urandom_range(0, 1500);
        tick_time = tick_time + step;
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) readout = 24'h000000;
      else if (roll < 12) readout = ProbeAllOnes;
      else readout = 24'($urandom());
      send_tick(tick_time, 1'($urandom_range(0, 1)), readout);
    end
  endtask

  // top of the time range with the longest blanking: the blanking and probe deadlines clamp
  task automatic test_saturation();
    wait_drained();
    reconfigure(32'hffff_ffff, 32'hffff_ffff);
    send_tick(32'hffff_ff00, 1'b1, 24'habcdef);
    send_tick(32'hffff_ff00, 1'b1, 24'h5a5a5a);
    send_tick(32'hffff_fffe, 1'b1, 24'h123456);
    send_tick(32'hffff_ffff, 1'b1, 24'h5a5a5a);
    send_tick(32'hffff_ffff, 1'b1, ProbeAllOnes);
  endtask

  // result side stall, redrawn after every word taken
  initial begin : result_stall
    int unsigned hold;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // compare every word taken against the oldest expectation
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_reports.size() == 0) begin
        report_mismatch("unexpected word, mode_now", mode_now_o, 0);
      end else begin
        want = due_reports.pop_front();
        if (motion_event_o !== want.motion_event)
          report_mismatch("motion_event", motion_event_o, want.motion_event);
        if (error_event_o !== want.error_event)
          report_mismatch("error_event", error_event_o, want.error_event);
        if (clear_event_o !== want.clear_event)
          report_mismatch("clear_event", clear_event_o, want.clear_event);
        if (send_probe_o !== want.send_probe)
          report_mismatch("send_probe", send_probe_o, want.send_probe);
        if (send_config_o !== want.send_config)
          report_mismatch("send_config", send_config_o, want.send_config);
        if (config_word_o !== want.config_word)
          report_mismatch("config_word", config_word_o, want.config_word);
        if (next_delay_o !== want.next_delay)
          report_mismatch("next_delay", next_delay_o, want.next_delay);
        if (motion_valid_o !== want.motion_valid)
          report_mismatch("motion_valid", motion_valid_o, want.motion_valid);
        if (mode_now_o !== want.mode_now)
          report_mismatch("mode_now", mode_now_o, want.mode_now);
      end
    end
  end

  // hang detector: too long with no word moving on either side
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("** pir_sensor_supervisor: FAILED **");
        $finish;
      end
    end
  end

  initial begin : main
    mismatch_count = 0;
    quiet_cycles   = 0;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    tick_time      = '0;
    // reset state of the block
    sup_mode       = ModeInit;
    sup_ignore_at  = '0;
    sup_blank_at   = '0;
    sup_probe_at   = '0;
    sup_latched    = 1'b0;
    sup_sens       = SensReset;
    sup_blank_len  = BlankReset;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= RegSensitivity;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    now_i           <= '0;
    motion_level_i  <= 1'b0;
    probe_readout_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_ignore_window();
    test_motion_blanking();
    test_probe_failure();
    test_sensitivity();
    test_random_ticks();
    test_saturation();

    wait_drained();
    // keep the clock running so a stray extra word would still be caught
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** pir_sensor_supervisor: PASSED **");
    end else begin
      $display("** pir_sensor_supervisor: FAILED **");
    end
    $finish;
  end

endmodule

### pir_sensor_supervisor.f
+incdir+sv
sv/pss_pkg.sv
sv/pss_in_stage.sv
sv/pss_core.sv
sv/pir_sensor_supervisor.sv
tb/testbench.sv
